// ===== hdl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants for the MOV-subset executor: opcode patterns,
// decoded command word, result word and operation codes.
// ----------------------------------------------------------------------------
package mse_pkg;

    // Item kinds
    localparam logic [1:0] KIND_EXEC = 2'd0;
    localparam logic [1:0] KIND_LOAD = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Opcode patterns
    localparam logic [5:0] OPC_MOV_RM      = 6'b100010;
    localparam logic [3:0] OPC_MOV_IMM_REG = 4'b1011;
    localparam logic [6:0] OPC_MOV_IMM_MEM = 7'b1100011;

    // ModRM mode field
    localparam logic [1:0] MOD_NONE   = 2'b00;
    localparam logic [1:0] MOD_DISP8  = 2'b01;
    localparam logic [1:0] MOD_DISP16 = 2'b10;
    localparam logic [1:0] MOD_REG    = 2'b11;

    // Instruction lengths
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

    // Width of an effective address sum before wrapping
    localparam int EA_SUM_BITS = 18;

    // Command queue between decoder and execution unit
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [3:0] op_t;

    localparam op_t OP_NOP      = 4'd0;
    localparam op_t OP_FAULT    = 4'd1;
    localparam op_t OP_MOVE_RR  = 4'd2;
    localparam op_t OP_MOVE_LD  = 4'd3;
    localparam op_t OP_MOVE_ST  = 4'd4;
    localparam op_t OP_IMM_REG  = 4'd5;
    localparam op_t OP_IMM_MEM  = 4'd6;
    localparam op_t OP_MEM_LOAD = 4'd7;
    localparam op_t OP_MEM_READ = 4'd8;

    // Decoded command word
    typedef struct packed {
        op_t         op;
        logic        w;
        logic [2:0]  src;
        logic [2:0]  dst;
        logic [2:0]  rm;
        logic [15:0] disp;
        logic        wrap16;
        logic [15:0] imm;
        logic [2:0]  len;
        logic [15:0] maddr;
        logic [7:0]  mbyte;
    } mse_cmd_t;

    // Result word
    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] cx;
        logic [15:0] dx;
        logic [15:0] bx;
        logic [15:0] sp;
        logic [15:0] bp;
        logic [15:0] si;
        logic [15:0] di;
        logic [15:0] ip;
        logic        fault;
        logic [7:0]  rd;
    } mse_result_t;

endpackage

// ===== hdl/mse_decode.sv =====
// ----------------------------------------------------------------------------
// mse_decode
// Front end: classifies each incoming word into a command for the execution
// unit, resolving opcode form, operand direction, displacement and length.
// ----------------------------------------------------------------------------
module mse_decode
    import mse_pkg::*;
(
    input  logic [1:0] kind,
    input  logic [7:0] instr_byte0,
    input  logic [7:0] instr_byte1,
    input  logic [7:0] instr_byte2,
    input  logic [7:0] instr_byte3,
    input  logic [15:0] mem_address,
    input  logic [7:0] mem_byte_in,
    output mse_cmd_t   cmd
);

    logic [1:0] mode;
    logic [2:0] rg;
    logic [2:0] rm;
    logic [15:0] w16;

    assign mode = instr_byte1[7:6];
    assign rg   = instr_byte1[5:3];
    assign rm   = instr_byte1[2:0];
    assign w16  = {instr_byte3, instr_byte2};

    // Classify the word
    always_comb
    begin
        cmd        = '0;
        cmd.op     = OP_NOP;
        cmd.rm     = rm;
        cmd.maddr  = mem_address;
        cmd.mbyte  = mem_byte_in;
        unique case (kind)
            KIND_EXEC:
            begin
                priority if (instr_byte0[7:2] == OPC_MOV_RM)
                begin
                    cmd.w      = instr_byte0[0];
                    cmd.wrap16 = (mode == MOD_DISP8);
                    unique case (mode)
                        MOD_DISP8:
                        begin
                            cmd.disp = {{8{instr_byte2[7]}}, instr_byte2};
                            cmd.len  = LEN_3;
                        end
                        MOD_DISP16:
                        begin
                            cmd.disp = w16;
                            cmd.len  = LEN_4;
                        end
                        default:
                        begin
                            cmd.disp = '0;
                            cmd.len  = LEN_2;
                        end
                    endcase
                    if (mode == MOD_REG)
                    begin
                        cmd.op  = OP_MOVE_RR;
                        cmd.src = instr_byte0[1] ? rm : rg;
                        cmd.dst = instr_byte0[1] ? rg : rm;
                    end
                    else if (instr_byte0[1])
                    begin
                        cmd.op  = OP_MOVE_LD;
                        cmd.dst = rg;
                    end
                    else
                    begin
                        cmd.op  = OP_MOVE_ST;
                        cmd.src = rg;
                    end
                end
                else if (instr_byte0[7:4] == OPC_MOV_IMM_REG)
                begin
                    cmd.op  = OP_IMM_REG;
                    cmd.w   = instr_byte0[3];
                    cmd.dst = instr_byte0[2:0];
                    cmd.imm = instr_byte0[3] ? {instr_byte2, instr_byte1}
                                             : {8'h00, instr_byte1};
                    cmd.len = instr_byte0[3] ? LEN_3 : LEN_2;
                end
                else if (instr_byte0[7:1] == OPC_MOV_IMM_MEM)
                begin
                    cmd.w   = instr_byte0[0];
                    cmd.imm = instr_byte0[0] ? w16 : {8'h00, instr_byte2};
                    cmd.len = instr_byte0[0] ? LEN_4 : LEN_3;
                    cmd.op  = (mode == MOD_NONE) ? OP_IMM_MEM : OP_FAULT;
                end
                else
                begin
                    cmd.op = OP_FAULT;
                end
            end
            KIND_LOAD: cmd.op = OP_MEM_LOAD;
            KIND_READ: cmd.op = OP_MEM_READ;
            default:   cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== hdl/mse_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// mse_cmd_queue
// Short command queue between the decoder and the execution unit, so that
// each side stalls on its own.
// ----------------------------------------------------------------------------
module mse_cmd_queue
    import mse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  mse_cmd_t cmd_in,
    input  logic     pop,
    output logic     full,
    output logic     empty,
    output mse_cmd_t head
);

    mse_cmd_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg;
    logic [QPTR_BITS:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

// ===== hdl/mse_execute.sv =====
// ----------------------------------------------------------------------------
// mse_execute
// Back end: holds the register file, instruction pointer and data memory,
// carries out one command at a time and keeps the finished result word in
// an output register.
// ----------------------------------------------------------------------------
module mse_execute
    import mse_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  mse_cmd_t    q_head,
    output logic        q_pop,
    input  logic        pop,
    output logic        empty,
    output mse_result_t res
);

    localparam int MEM_BYTES = 1 << ADDR_BITS;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_LD_LO   = 3'd2;
    localparam logic [2:0] S_LD_HI   = 3'd3;
    localparam logic [2:0] S_WR_HI   = 3'd4;
    localparam logic [2:0] S_RD_BYTE = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]           state_reg,  state_next;
    mse_cmd_t             cmd_reg,    cmd_next;
    logic [15:0]          regs_reg [8];
    logic [15:0]          ip_reg,     ip_next;
    logic                 fault_reg,  fault_next;
    logic [7:0]           rd_reg,     rd_next;
    logic [ADDR_BITS-1:0] ea_reg,     ea_next;
    logic [7:0]           hi_reg,     hi_next;
    logic [7:0]           lo_reg,     lo_next;
    mse_result_t          res_reg;
    logic                 res_valid_reg, res_valid_next;
    logic                 res_load;

    logic [7:0]           mem [MEM_BYTES];
    logic [7:0]           mem_q_reg;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_wa;
    logic [7:0]           mem_wd;
    logic                 mem_re;
    logic [ADDR_BITS-1:0] mem_ra;

    logic                 rf_we;
    logic [2:0]           rf_idx;
    logic                 rf_hi;
    logic [15:0]          rf_data;

    logic [2:0]           src_phys;
    logic [15:0]          src_word;
    logic [15:0]          src_val;
    logic [2:0]           dst_phys;
    logic [16:0]          ea_base;
    logic [EA_SUM_BITS-1:0] ea_sum;
    logic [ADDR_BITS-1:0] ea_calc;
    logic [15:0]          wr_val;

    assign empty = !res_valid_reg;
    assign res   = res_reg;

    // Resolve byte register halves: al..bl low bytes, ah..bh high bytes
    assign src_phys = cmd_reg.w ? cmd_reg.src : {1'b0, cmd_reg.src[1:0]};
    assign src_word = regs_reg[src_phys];
    assign src_val  = cmd_reg.w ? src_word
                    : (cmd_reg.src[2] ? {8'h00, src_word[15:8]} : {8'h00, src_word[7:0]});
    assign dst_phys = cmd_reg.w ? cmd_reg.dst : {1'b0, cmd_reg.dst[1:0]};

    // Effective address from the rm table plus displacement
    always_comb
    begin
        unique case (cmd_reg.rm)
            3'd0:    ea_base = {1'b0, regs_reg[3]} + {1'b0, regs_reg[6]};
            3'd1:    ea_base = {1'b0, regs_reg[3]} + {1'b0, regs_reg[7]};
            3'd2:    ea_base = {1'b0, regs_reg[5]} + {1'b0, regs_reg[6]};
            3'd3:    ea_base = {1'b0, regs_reg[5]} + {1'b0, regs_reg[7]};
            3'd4:    ea_base = {1'b0, regs_reg[6]};
            3'd5:    ea_base = {1'b0, regs_reg[7]};
            3'd6:    ea_base = {1'b0, regs_reg[5]};
            default: ea_base = {1'b0, regs_reg[3]};
        endcase
        ea_sum = {1'b0, ea_base} + {2'b00, cmd_reg.disp};
        if (cmd_reg.wrap16)
            ea_sum = {2'b00, ea_sum[15:0]};
        ea_calc = ADDR_BITS'(ea_sum);
    end

    assign wr_val   = (cmd_reg.op == OP_IMM_MEM) ? cmd_reg.imm : src_val;
    assign res_load = (state_reg == S_DONE) && (!res_valid_reg || pop);

    // Sequence one command
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ip_next    = ip_reg;
        fault_next = fault_reg;
        rd_next    = rd_reg;
        ea_next    = ea_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = ea_calc;
        mem_wd     = wr_val[7:0];
        mem_re     = 1'b0;
        mem_ra     = ea_calc;
        rf_we      = 1'b0;
        rf_idx     = dst_phys;
        rf_hi      = !cmd_reg.w && cmd_reg.dst[2];
        rf_data    = src_val;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    fault_next = 1'b0;
                    rd_next    = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (cmd_reg.op)
                    OP_MOVE_RR:
                    begin
                        rf_we   = 1'b1;
                        ip_next = ip_reg + {13'd0, cmd_reg.len};
                    end
                    OP_IMM_REG:
                    begin
                        rf_we   = 1'b1;
                        rf_data = cmd_reg.imm;
                        ip_next = ip_reg + {13'd0, cmd_reg.len};
                    end
                    OP_MOVE_ST, OP_IMM_MEM:
                    begin
                        mem_we  = 1'b1;
                        hi_next = wr_val[15:8];
                        ea_next = ea_calc;
                        ip_next = ip_reg + {13'd0, cmd_reg.len};
                        if (cmd_reg.w)
                            state_next = S_WR_HI;
                    end
                    OP_MOVE_LD:
                    begin
                        mem_re     = 1'b1;
                        ea_next    = ea_calc;
                        ip_next    = ip_reg + {13'd0, cmd_reg.len};
                        state_next = S_LD_LO;
                    end
                    OP_MEM_LOAD:
                    begin
                        mem_we = 1'b1;
                        mem_wa = ADDR_BITS'(cmd_reg.maddr);
                        mem_wd = cmd_reg.mbyte;
                    end
                    OP_MEM_READ:
                    begin
                        mem_re     = 1'b1;
                        mem_ra     = ADDR_BITS'(cmd_reg.maddr);
                        state_next = S_RD_BYTE;
                    end
                    OP_FAULT:
                    begin
                        fault_next = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_LD_LO:
            begin
                if (cmd_reg.w)
                begin
                    lo_next    = mem_q_reg;
                    mem_re     = 1'b1;
                    mem_ra     = ea_reg + 1'b1;
                    state_next = S_LD_HI;
                end
                else
                begin
                    rf_we      = 1'b1;
                    rf_data    = {8'h00, mem_q_reg};
                    state_next = S_DONE;
                end
            end
            S_LD_HI:
            begin
                rf_we      = 1'b1;
                rf_data    = {mem_q_reg, lo_reg};
                state_next = S_DONE;
            end
            S_WR_HI:
            begin
                mem_we     = 1'b1;
                mem_wa     = ea_reg + 1'b1;
                mem_wd     = hi_reg;
                state_next = S_DONE;
            end
            S_RD_BYTE:
            begin
                rd_next    = mem_q_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold or drop the result word
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (pop)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ip_reg        <= '0;
            fault_reg     <= 1'b0;
            rd_reg        <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                regs_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ip_reg        <= ip_next;
            fault_reg     <= fault_next;
            rd_reg        <= rd_next;
            res_valid_reg <= res_valid_next;
            if (rf_we)
            begin
                if (cmd_reg.w)
                    regs_reg[rf_idx] <= rf_data;
                else if (rf_hi)
                    regs_reg[rf_idx][15:8] <= rf_data[7:0];
                else
                    regs_reg[rf_idx][7:0] <= rf_data[7:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        ea_reg  <= ea_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        if (res_load)
        begin
            res_reg.ax    <= regs_reg[0];
            res_reg.cx    <= regs_reg[1];
            res_reg.dx    <= regs_reg[2];
            res_reg.bx    <= regs_reg[3];
            res_reg.sp    <= regs_reg[4];
            res_reg.bp    <= regs_reg[5];
            res_reg.si    <= regs_reg[6];
            res_reg.di    <= regs_reg[7];
            res_reg.ip    <= ip_reg;
            res_reg.fault <= fault_reg;
            res_reg.rd    <= rd_reg;
        end
    end

    // Data memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_q_reg <= mem[mem_ra];
    end

    // The instruction pointer moves only while a command executes
    a_ip_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(ip_reg))
        else $error("instruction pointer changed outside execute");

    // Second-byte states only serve word accesses
    a_second_byte_is_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LD_HI || state_reg == S_WR_HI) |-> cmd_reg.w)
        else $error("second byte access on a byte operation");

    // A command leaves the queue only when the unit is free
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE) && !q_empty)
        else $error("command taken while busy");

    // A faulted word never carries read data
    a_fault_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && fault_reg |-> (rd_reg == '0))
        else $error("fault result carries read data");

    // Memory port never reads and writes in the same cycle
    a_one_mem_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("memory read and write collide");

endmodule

// ===== hdl/mov_subset_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// mov_subset_instruction_executor
// Executes one 8086-style MOV (register/memory, immediate to register,
// immediate to memory) or a data memory load/read per word.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+-----------------------------------------
//   input    | push / full        | kind, instr_byte0..3, mem_address,
//            |                    | mem_byte_in
//   result   | empty / pop        | reg_ax..reg_di, next_ip, fault,
//            |                    | mem_byte_out
//
// Register moves, faults, memory loads and byte stores pass through the
// execute and done states of the execution unit; word stores add a second
// write state, byte memory loads and reads a read-data state, and word memory
// loads a low and a high read-data state, as the single data memory port moves one byte at a time.
// Decoded words wait in a two-entry queue, so input is taken while the
// execution unit works or a result waits to be popped, until the queue is full.
// Reset clears registers and the instruction pointer; memory is undefined
// until written.
// ----------------------------------------------------------------------------
module mov_subset_instruction_executor
    import mse_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [7:0]  instr_byte0,
    input  logic [7:0]  instr_byte1,
    input  logic [7:0]  instr_byte2,
    input  logic [7:0]  instr_byte3,
    input  logic [15:0] mem_address,
    input  logic [7:0]  mem_byte_in,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] reg_ax,
    output logic [15:0] reg_cx,
    output logic [15:0] reg_dx,
    output logic [15:0] reg_bx,
    output logic [15:0] reg_sp,
    output logic [15:0] reg_bp,
    output logic [15:0] reg_si,
    output logic [15:0] reg_di,
    output logic [15:0] next_ip,
    output logic        fault,
    output logic [7:0]  mem_byte_out
);

    mse_cmd_t    dec_cmd;
    mse_cmd_t    q_head;
    logic        q_empty;
    logic        q_pop;
    mse_result_t res;

    // Classify incoming words
    mse_decode u_decode (
        .kind        (kind),
        .instr_byte0 (instr_byte0),
        .instr_byte1 (instr_byte1),
        .instr_byte2 (instr_byte2),
        .instr_byte3 (instr_byte3),
        .mem_address (mem_address),
        .mem_byte_in (mem_byte_in),
        .cmd         (dec_cmd)
    );

    // Buffer decoded words
    mse_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd_in (dec_cmd),
        .pop    (q_pop),
        .full   (full),
        .empty  (q_empty),
        .head   (q_head)
    );

    // Carry out commands
    mse_execute #(
        .ADDR_BITS (ADDR_BITS)
    ) u_execute (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign reg_ax       = res.ax;
    assign reg_cx       = res.cx;
    assign reg_dx       = res.dx;
    assign reg_bx       = res.bx;
    assign reg_sp       = res.sp;
    assign reg_bp       = res.bp;
    assign reg_si       = res.si;
    assign reg_di       = res.di;
    assign next_ip      = res.ip;
    assign fault        = res.fault;
    assign mem_byte_out = res.rd;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb - MOV-subset instruction executor testbench
// Drives instruction, memory load and memory read words through the push/full
// queue, keeps a local model of the register file, instruction pointer and
// data memory, and checks every popped result word field by field. Directed
// corner cases come first, then random programs and a back-to-back burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import mse_pkg::*;

    localparam int  STALL_LIMIT  = 1000;
    localparam int  DRAIN_CYCLES = 16;
    localparam int  IDLE_PCT     = 6;

    localparam logic [1:0] KIND_NONE   = 2'd3;
    localparam logic [7:0] OPC_UNKNOWN = 8'h90;
    localparam logic [2:0] LEN_FAULT   = 3'd0;

    // Word register numbers and their byte halves
    localparam logic [2:0] R_AX = 3'd0, R_CX = 3'd1, R_DX = 3'd2, R_BX = 3'd3;
    localparam logic [2:0] R_SP = 3'd4, R_BP = 3'd5, R_SI = 3'd6, R_DI = 3'd7;
    localparam logic [2:0] R_AL = 3'd0, R_CL = 3'd1, R_DL = 3'd2, R_BL = 3'd3;
    localparam logic [2:0] R_AH = 3'd4, R_CH = 3'd5, R_DH = 3'd6, R_BH = 3'd7;

    // Effective address forms of the rm field
    localparam logic [2:0] RM_BX_SI = 3'd0, RM_BX_DI = 3'd1;
    localparam logic [2:0] RM_BP_SI = 3'd2, RM_BP_DI = 3'd3;
    localparam logic [2:0] RM_SI    = 3'd4, RM_DI    = 3'd5;
    localparam logic [2:0] RM_BP    = 3'd6, RM_BX    = 3'd7;

    localparam logic W_BYTE = 1'b0, W_WORD = 1'b1;
    localparam logic TO_RM  = 1'b0, TO_REG = 1'b1;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [15:0] addr;
        logic [7:0]  data;
    } mov_item_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  kind;
    logic [7:0]  instr_byte0;
    logic [7:0]  instr_byte1;
    logic [7:0]  instr_byte2;
    logic [7:0]  instr_byte3;
    logic [15:0] mem_address;
    logic [7:0]  mem_byte_in;
    logic        empty;
    logic        pop;
    logic [15:0] reg_ax;
    logic [15:0] reg_cx;
    logic [15:0] reg_dx;
    logic [15:0] reg_bx;
    logic [15:0] reg_sp;
    logic [15:0] reg_bp;
    logic [15:0] reg_si;
    logic [15:0] reg_di;
    logic [15:0] next_ip;
    logic        fault;
    logic [7:0]  mem_byte_out;

    // Model state
    logic [15:0] gpr [8];
    logic [15:0] ip_model;
    logic [7:0]  mem_img [bit [15:0]];
    logic [15:0] filled_addrs [$];

    mse_result_t arch_state_q [$];
    mse_result_t head;

    bit quiet;
    int mismatches;
    int stall_cycles;
    int n_exec, n_fault, n_load, n_read, n_checked;

    mov_subset_instruction_executor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .instr_byte0  (instr_byte0),
        .instr_byte1  (instr_byte1),
        .instr_byte2  (instr_byte2),
        .instr_byte3  (instr_byte3),
        .mem_address  (mem_address),
        .mem_byte_in  (mem_byte_in),
        .empty        (empty),
        .pop          (pop),
        .reg_ax       (reg_ax),
        .reg_cx       (reg_cx),
        .reg_dx       (reg_dx),
        .reg_bx       (reg_bx),
        .reg_sp       (reg_sp),
        .reg_bp       (reg_bp),
        .reg_si       (reg_si),
        .reg_di       (reg_di),
        .next_ip      (next_ip),
        .fault        (fault),
        .mem_byte_out (mem_byte_out)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the executor
    // ------------------------------------------------------------------
    function automatic logic [15:0] gpr_read(logic [2:0] r, logic w);
        if (w)
            return gpr[r];
        if (!r[2])
            return {8'h00, gpr[r][7:0]};
        return {8'h00, gpr[{1'b0, r[1:0]}][15:8]};
    endfunction

    function automatic void gpr_write(logic [2:0] r, logic w, logic [15:0] v);
        if (w)
            gpr[r] = v;
        else if (!r[2])
            gpr[r][7:0] = v[7:0];
        else
            gpr[{1'b0, r[1:0]}][15:8] = v[7:0];
    endfunction

    function automatic logic [7:0] mem_byte(logic [15:0] a);
        if (mem_img.exists(a))
            return mem_img[a];
        return 8'h00;
    endfunction

    function automatic logic [15:0] mem_fetch(logic [15:0] a, logic w);
        logic [15:0] a1;
        a1 = a + 16'd1;
        if (!w)
            return {8'h00, mem_byte(a)};
        return {mem_byte(a1), mem_byte(a)};
    endfunction

    function automatic void mem_put(logic [15:0] a, logic [7:0] v);
        if (!mem_img.exists(a))
            filled_addrs.push_back(a);
        mem_img[a] = v;
    endfunction

    function automatic void mem_store(logic [15:0] a, logic w, logic [15:0] v);
        mem_put(a, v[7:0]);
        if (w)
            mem_put(a + 16'd1, v[15:8]);
    endfunction

    // Effective address of a memory operand; 16-bit sums wrap with the memory
    function automatic logic [15:0] operand_addr(logic [7:0] b1, logic [7:0] b2,
                                                 logic [7:0] b3);
        logic [15:0] a;
        case (b1[2:0])
            RM_BX_SI: a = gpr[R_BX] + gpr[R_SI];
            RM_BX_DI: a = gpr[R_BX] + gpr[R_DI];
            RM_BP_SI: a = gpr[R_BP] + gpr[R_SI];
            RM_BP_DI: a = gpr[R_BP] + gpr[R_DI];
            RM_SI:    a = gpr[R_SI];
            RM_DI:    a = gpr[R_DI];
            RM_BP:    a = gpr[R_BP];
            default:  a = gpr[R_BX];
        endcase
        if (b1[7:6] == MOD_DISP8)
            a = a + {{8{b2[7]}}, b2};
        else if (b1[7:6] == MOD_DISP16)
            a = a + {b3, b2};
        return a;
    endfunction

    // Execute one instruction on the model; return its length, zero on fault
    function automatic logic [2:0] execute_mov(logic [7:0] b0, logic [7:0] b1,
                                               logic [7:0] b2, logic [7:0] b3);
        logic [15:0] a;
        logic [2:0]  len;
        if (b0[7:2] == OPC_MOV_RM) begin
            if (b1[7:6] == MOD_REG) begin
                if (b0[1] == TO_REG)
                    gpr_write(b1[5:3], b0[0], gpr_read(b1[2:0], b0[0]));
                else
                    gpr_write(b1[2:0], b0[0], gpr_read(b1[5:3], b0[0]));
                return LEN_2;
            end
            a = operand_addr(b1, b2, b3);
            len = (b1[7:6] == MOD_DISP8) ? LEN_3 :
                  (b1[7:6] == MOD_DISP16) ? LEN_4 : LEN_2;
            if (b0[1] == TO_REG)
                gpr_write(b1[5:3], b0[0], mem_fetch(a, b0[0]));
            else
                mem_store(a, b0[0], gpr_read(b1[5:3], b0[0]));
            return len;
        end
        if (b0[7:4] == OPC_MOV_IMM_REG) begin
            gpr_write(b0[2:0], b0[3], b0[3] ? {b2, b1} : {8'h00, b1});
            return b0[3] ? LEN_3 : LEN_2;
        end
        if (b0[7:1] == OPC_MOV_IMM_MEM) begin
            if (b1[7:6] != MOD_NONE)
                return LEN_FAULT;
            mem_store(operand_addr({MOD_NONE, b1[5:0]}, b2, b3), b0[0],
                      b0[0] ? {b3, b2} : {8'h00, b2});
            return b0[0] ? LEN_4 : LEN_3;
        end
        return LEN_FAULT;
    endfunction

    // Apply one accepted word to the model and return the state it leaves
    function automatic mse_result_t state_after(mov_item_t it);
        mse_result_t r;
        logic [2:0]  len;
        r.fault = 1'b0;
        r.rd    = 8'h00;
        if (it.kind == KIND_EXEC) begin
            n_exec++;
            len = execute_mov(it.b0, it.b1, it.b2, it.b3);
            if (len == LEN_FAULT) begin
                r.fault = 1'b1;
                n_fault++;
            end
            else begin
                ip_model = ip_model + 16'(len);
            end
        end
        else if (it.kind == KIND_LOAD) begin
            n_load++;
            mem_put(it.addr, it.data);
        end
        else if (it.kind == KIND_READ) begin
            n_read++;
            r.rd = mem_byte(it.addr);
        end
        r.ax = gpr[R_AX];
        r.cx = gpr[R_CX];
        r.dx = gpr[R_DX];
        r.bx = gpr[R_BX];
        r.sp = gpr[R_SP];
        r.bp = gpr[R_BP];
        r.si = gpr[R_SI];
        r.di = gpr[R_DI];
        r.ip = ip_model;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic mov_item_t noise_item();
        mov_item_t it;
        it.kind = 2'($urandom);
        it.b0   = 8'($urandom);
        it.b1   = 8'($urandom);
        it.b2   = 8'($urandom);
        it.b3   = 8'($urandom);
        it.addr = 16'($urandom);
        it.data = 8'($urandom);
        return it;
    endfunction

    function automatic mov_item_t exec_item(logic [7:0] b0, logic [7:0] b1,
                                            logic [7:0] b2, logic [7:0] b3);
        mov_item_t it;
        it = noise_item();
        it.kind = KIND_EXEC;
        it.b0 = b0;
        it.b1 = b1;
        it.b2 = b2;
        it.b3 = b3;
        return it;
    endfunction

    function automatic mov_item_t mem_item(logic [1:0] k, logic [15:0] a, logic [7:0] d);
        mov_item_t it;
        it = noise_item();
        it.kind = k;
        it.addr = a;
        it.data = d;
        return it;
    endfunction

    function automatic logic [7:0] modrm(logic [1:0] md, logic [2:0] rg, logic [2:0] rm);
        return {md, rg, rm};
    endfunction

    // ------------------------------------------------------------------
    // Input side: push one word, record its expected state once accepted
    // ------------------------------------------------------------------
    task automatic send_word(mov_item_t it);
        // hold push low on random cycles
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push        <= 1'b1;
        kind        <= it.kind;
        instr_byte0 <= it.b0;
        instr_byte1 <= it.b1;
        instr_byte2 <= it.b2;
        instr_byte3 <= it.b3;
        mem_address <= it.addr;
        mem_byte_in <= it.data;
        do
            @(posedge clk);
        while (full);
        arch_state_q.push_back(state_after(it));
        @(negedge clk);
    endtask

    // Send a word, first loading any memory byte it would read unwritten
    task automatic issue(mov_item_t it);
        logic [15:0] a;
        logic        two;
        bit          reads;
        reads = 1'b0;
        two   = 1'b0;
        a     = it.addr;
        if (it.kind == KIND_READ) begin
            reads = 1'b1;
        end
        else if (it.kind == KIND_EXEC && it.b0[7:2] == OPC_MOV_RM &&
                 it.b0[1] == TO_REG && it.b1[7:6] != MOD_REG) begin
            reads = 1'b1;
            two   = it.b0[0];
            a     = operand_addr(it.b1, it.b2, it.b3);
        end
        if (reads && !mem_img.exists(a))
            send_word(mem_item(KIND_LOAD, a, 8'($urandom)));
        if (two && !mem_img.exists(a + 16'd1))
            send_word(mem_item(KIND_LOAD, a + 16'd1, 8'($urandom)));
        send_word(it);
    endtask

    task automatic run_exec(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                            logic [7:0] b3);
        issue(exec_item(b0, b1, b2, b3));
    endtask

    // One random word: mostly well-formed MOVs, some memory traffic, some noise
    task automatic random_word();
        mov_item_t it;
        int        pick;
        it   = noise_item();
        pick = $urandom_range(99);
        if (pick < 45) begin
            it.kind = KIND_EXEC;
            it.b0   = {OPC_MOV_RM, 2'($urandom)};
        end
        else if (pick < 65) begin
            it.kind = KIND_EXEC;
            it.b0   = {OPC_MOV_IMM_REG, 4'($urandom)};
        end
        else if (pick < 80) begin
            it.kind = KIND_EXEC;
            it.b0   = {OPC_MOV_IMM_MEM, 1'($urandom)};
            if ($urandom_range(99) < 85)
                it.b1[7:6] = MOD_NONE;
        end
        else if (pick < 88) begin
            it.kind = KIND_LOAD;
        end
        else if (pick < 95) begin
            it.kind = KIND_READ;
            if (filled_addrs.size() != 0)
                it.addr = filled_addrs[$urandom_range(filled_addrs.size() - 1)];
        end
        issue(it);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        // extremes of immediates and byte halves
        run_exec({OPC_MOV_IMM_REG, W_WORD, R_AX}, 8'hFF, 8'hFF, 8'h00);
        run_exec({OPC_MOV_IMM_REG, W_WORD, R_BX}, 8'hFF, 8'hFF, 8'h00);
        run_exec({OPC_MOV_IMM_REG, W_WORD, R_SI}, 8'h01, 8'h00, 8'h00);
        run_exec({OPC_MOV_IMM_REG, W_BYTE, R_AH}, 8'h00, 8'hFF, 8'hFF);
        run_exec({OPC_MOV_IMM_REG, W_BYTE, R_CH}, 8'hA5, 8'h00, 8'h00);
        run_exec({OPC_MOV_IMM_REG, W_BYTE, R_DL}, 8'h5A, 8'h00, 8'h00);
        // word store where bx+si wraps to zero
        run_exec({OPC_MOV_RM, TO_RM, W_WORD}, modrm(MOD_NONE, R_AX, RM_BX_SI), 8'h00, 8'h00);
        // negative 8-bit displacement
        run_exec({OPC_MOV_RM, TO_RM, W_WORD}, modrm(MOD_DISP8, R_CX, RM_BX_DI), 8'hFF, 8'h00);
        // immediate to [bp] with mod 00; reg field is ignored
        run_exec({OPC_MOV_IMM_MEM, W_WORD}, modrm(MOD_NONE, 3'b111, RM_BP), 8'h34, 8'h12);
        // word load through a 16-bit displacement that wraps
        run_exec({OPC_MOV_RM, TO_REG, W_WORD}, modrm(MOD_DISP16, R_DX, RM_BX), 8'h01, 8'h00);
        // word store at the top address, second byte wraps to zero
        run_exec({OPC_MOV_IMM_REG, W_WORD, R_DI}, 8'hFF, 8'hFF, 8'h00);
        run_exec({OPC_MOV_RM, TO_RM, W_WORD}, modrm(MOD_NONE, R_AX, RM_DI), 8'h00, 8'h00);
        // byte load into a high half, register moves both directions
        run_exec({OPC_MOV_RM, TO_REG, W_BYTE}, modrm(MOD_NONE, R_BH, RM_SI), 8'h00, 8'h00);
        run_exec({OPC_MOV_RM, TO_RM, W_BYTE}, modrm(MOD_REG, R_AH, R_CL), 8'h00, 8'h00);
        run_exec({OPC_MOV_RM, TO_REG, W_WORD}, modrm(MOD_REG, R_SP, R_BX), 8'h00, 8'h00);
        run_exec({OPC_MOV_IMM_MEM, W_BYTE}, modrm(MOD_NONE, 3'b000, RM_BP_SI), 8'h7F, 8'h00);
        // faults: immediate to memory with a displacement or register mode, unknown opcode
        run_exec({OPC_MOV_IMM_MEM, W_BYTE}, modrm(MOD_DISP8, 3'b000, RM_BX), 8'h11, 8'h22);
        run_exec({OPC_MOV_IMM_MEM, W_WORD}, modrm(MOD_REG, 3'b000, RM_BX), 8'h11, 8'h22);
        run_exec(OPC_UNKNOWN, 8'hFF, 8'hFF, 8'hFF);
        // unused kind does nothing
        issue(mem_item(KIND_NONE, 16'hFFFF, 8'hFF));
        // direct memory load and read at both ends
        issue(mem_item(KIND_LOAD, 16'hFFFF, 8'hFF));
        issue(mem_item(KIND_LOAD, 16'h0000, 8'h00));
        issue(mem_item(KIND_READ, 16'hFFFF, 8'h00));
        issue(mem_item(KIND_READ, 16'h0000, 8'hFF));
        // positive 8-bit displacement on a byte load
        run_exec({OPC_MOV_RM, TO_REG, W_BYTE}, modrm(MOD_DISP8, R_AL, RM_BP_DI), 8'h7F, 8'h00);
    endtask

    task automatic test_random_programs(int count);
        quiet = 1'b0;
        repeat (count)
            random_word();
    endtask

    task automatic test_back_to_back(int count);
        quiet = 1'b1;
        repeat (count)
            random_word();
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(negedge clk)
        pop <= rst_n && (quiet || $urandom_range(99) >= IDLE_PCT);

    task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Compare each popped word with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            if (arch_state_q.size() == 0) begin
                $display("%0t: result word with nothing expected, actual ip %h",
                         $time, next_ip);
                mismatches++;
            end
            else begin
                head = arch_state_q.pop_front();
                n_checked++;
                check_field("reg_ax", head.ax, reg_ax);
                check_field("reg_cx", head.cx, reg_cx);
                check_field("reg_dx", head.dx, reg_dx);
                check_field("reg_bx", head.bx, reg_bx);
                check_field("reg_sp", head.sp, reg_sp);
                check_field("reg_bp", head.bp, reg_bp);
                check_field("reg_si", head.si, reg_si);
                check_field("reg_di", head.di, reg_di);
                check_field("next_ip", head.ip, next_ip);
                check_field("fault", {15'h0, head.fault}, {15'h0, fault});
                check_field("mem_byte_out", {8'h00, head.rd}, {8'h00, mem_byte_out});
            end
        end
    end

    // Abort when nothing moves on either side for too long
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, arch_state_q.size());
            $display("mov_subset_instruction_executor test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        kind         = KIND_EXEC;
        instr_byte0  = 8'h00;
        instr_byte1  = 8'h00;
        instr_byte2  = 8'h00;
        instr_byte3  = 8'h00;
        mem_address  = 16'h0000;
        mem_byte_in  = 8'h00;
        quiet        = 1'b0;
        mismatches   = 0;
        stall_cycles = 0;
        ip_model     = 16'h0000;
        foreach (gpr[i])
            gpr[i] = 16'h0000;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_programs(700);
        test_back_to_back(250);

        push <= 1'b0;
        while (arch_state_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d instructions (%0d faulting), %0d memory loads, %0d reads;",
                 n_exec, n_fault, n_load, n_read);
        $display("%0d result words checked with random and no idling, %0d mismatches.",
                 n_checked, mismatches);
        if (mismatches == 0 && arch_state_q.size() == 0)
            $display("mov_subset_instruction_executor test passed");
        else
            $display("mov_subset_instruction_executor test failed");
        $finish;
    end

endmodule
